@@ design/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int FRAC_W       = FRAC_BITS + 1;        // saturation, value incl. 1.0
    localparam int HUE_W        = 15;
    localparam int LEVEL_W      = 8;
    localparam int SECTOR_UNITS = 3840;                 // 60 degrees in 1/64 degree
    localparam int SECTOR_COUNT = 6;
    localparam int WEIGHT_W     = 12;                   // holds 0..SECTOR_UNITS
    localparam int HM_W         = 13;                   // holds hue mod two sectors
    localparam int PROD_W       = 2 * FRAC_BITS + 1;    // chroma and dark part
    localparam int MIX_W        = 2 * FRAC_BITS + 12;   // SECTOR_UNITS << 2*FRAC_BITS fits
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 3 * LEVEL_W;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    typedef struct packed {
        logic [FRAC_W-1:0]   val;
        logic [FRAC_W-1:0]   sat;
        logic [WEIGHT_W-1:0] weight;
        sector_t             sector;
    } prep_t;

    typedef struct packed {
        logic [FRAC_W-1:0]   val;
        logic [PROD_W-1:0]   chroma;
        logic [WEIGHT_W-1:0] weight;
        sector_t             sector;
    } prod_t;

    typedef struct packed {
        logic [FRAC_W-1:0] val;
        logic [PROD_W-1:0] dark;
        logic [MIX_W-1:0]  cw;
        sector_t           sector;
    } part_t;

    typedef struct packed {
        logic [FRAC_W-1:0] val;
        logic [PROD_W-1:0] dark;
        logic [MIX_W-1:0]  mix;
        sector_t           sector;
    } mix_t;

    // blue on top so that red lands in the lowest bits of tdata
    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } rgb_t;

endpackage

@@ design/hsv2rgb_prep.sv @@
`timescale 1ns / 1ps

module hsv2rgb_prep (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]   saturation,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]   brightness,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hsv2rgb_pkg::prep_t               out_data
);
    import hsv2rgb_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    prep_t               data_reg;
    prep_t               data_next;
    logic [HM_W-1:0]     hue_base;
    logic [HM_W-1:0]     hue_mod;
    logic [2:0]          sector_cnt;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;

        // hue mod two sectors: strip whole multiples of 120 degrees
        hue_base = '0;
        for (int k = 1; k <= 4; k++) begin
            if (hue >= HUE_W'(k * 2 * SECTOR_UNITS)) begin
                hue_base = HM_W'(0);
            end
        end
        if (hue >= HUE_W'(8 * SECTOR_UNITS)) begin
            hue_mod = HM_W'(hue - HUE_W'(8 * SECTOR_UNITS));
        end else if (hue >= HUE_W'(6 * SECTOR_UNITS)) begin
            hue_mod = HM_W'(hue - HUE_W'(6 * SECTOR_UNITS));
        end else if (hue >= HUE_W'(4 * SECTOR_UNITS)) begin
            hue_mod = HM_W'(hue - HUE_W'(4 * SECTOR_UNITS));
        end else if (hue >= HUE_W'(2 * SECTOR_UNITS)) begin
            hue_mod = HM_W'(hue - HUE_W'(2 * SECTOR_UNITS));
        end else begin
            hue_mod = HM_W'(hue);
        end
        hue_mod = hue_mod | hue_base;

        // sector index, everything past the fifth boundary stays in the last one
        sector_cnt = '0;
        for (int k = 1; k < SECTOR_COUNT; k++) begin
            if (hue >= HUE_W'(k * SECTOR_UNITS)) begin
                sector_cnt = sector_cnt + 3'd1;
            end
        end

        data_next.val    = (brightness > FRAC_W'(ONE)) ? FRAC_W'(ONE) : brightness;
        data_next.sat    = (saturation > FRAC_W'(ONE)) ? FRAC_W'(ONE) : saturation;
        data_next.weight = (hue_mod < HM_W'(SECTOR_UNITS)) ? WEIGHT_W'(hue_mod)
                         : WEIGHT_W'(HM_W'(2 * SECTOR_UNITS) - hue_mod);
        data_next.sector = sector_t'(sector_cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/hsv2rgb_mult.sv @@
`timescale 1ns / 1ps

module hsv2rgb_mult (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsv2rgb_pkg::prep_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hsv2rgb_pkg::mix_t   out_data
);
    import hsv2rgb_pkg::*;

    logic                      prod_valid_reg;
    logic                      part_valid_reg;
    logic                      mix_valid_reg;
    logic                      prod_ready;
    logic                      part_ready;
    logic                      mix_ready;
    prod_t                     prod_reg;
    prod_t                     prod_next;
    part_t                     part_reg;
    part_t                     part_next;
    mix_t                      mix_reg;
    mix_t                      mix_next;
    logic [PROD_W+WEIGHT_W-1:0] cw_full;
    logic [MIX_W:0]            dark_scaled;
    logic [MIX_W:0]            mix_sum;

    assign mix_ready  = !mix_valid_reg  || out_ready;
    assign part_ready = !part_valid_reg || mix_ready;
    assign prod_ready = !prod_valid_reg || part_ready;
    assign in_ready   = prod_ready;
    assign out_valid  = mix_valid_reg;
    assign out_data   = mix_reg;

    always_comb begin
        // chroma = v * s
        prod_next.val    = in_data.val;
        prod_next.chroma = PROD_W'(in_data.val) * PROD_W'(in_data.sat);
        prod_next.weight = in_data.weight;
        prod_next.sector = in_data.sector;

        // dark part v*1.0 - chroma, secondary numerator chroma * weight
        cw_full          = prod_reg.chroma * prod_reg.weight;
        part_next.val    = prod_reg.val;
        part_next.dark   = {prod_reg.val, {FRAC_BITS{1'b0}}} - prod_reg.chroma;
        part_next.cw     = cw_full[MIX_W-1:0];
        part_next.sector = prod_reg.sector;

        // dark * 3840 as dark * 4096 - dark * 256
        dark_scaled      = {part_reg.dark, 12'b0} - {4'b0, part_reg.dark, 8'b0};
        mix_sum          = dark_scaled + {1'b0, part_reg.cw};
        mix_next.val     = part_reg.val;
        mix_next.dark    = part_reg.dark;
        mix_next.mix     = mix_sum[MIX_W-1:0];
        mix_next.sector  = part_reg.sector;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            part_valid_reg <= 1'b0;
            mix_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (part_ready) begin
                part_valid_reg <= prod_valid_reg;
            end
            if (mix_ready) begin
                mix_valid_reg <= part_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (part_ready && prod_valid_reg) begin
            part_reg <= part_next;
        end
        if (mix_ready && part_valid_reg) begin
            mix_reg <= mix_next;
        end
    end

endmodule

@@ design/hsv2rgb_level.sv @@
`timescale 1ns / 1ps

module hsv2rgb_level (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsv2rgb_pkg::mix_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsv2rgb_pkg::rgb_t  out_data
);
    import hsv2rgb_pkg::*;

    logic                      valid_reg;
    rgb_t                      rgb_reg;
    rgb_t                      rgb_next;
    logic [FRAC_W+7:0]         full_scaled;
    logic [PROD_W+7:0]         dark_scaled;
    logic [MIX_W+4:0]          mix_scaled;
    logic [LEVEL_W-1:0]        full_lvl;
    logic [LEVEL_W-1:0]        dark_lvl;
    logic [LEVEL_W-1:0]        mix_lvl;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

    always_comb begin
        // chroma + dark collapses to v: level = 255 * v / 1.0
        full_scaled = {in_data.val, 8'b0} - {8'b0, in_data.val};
        full_lvl    = full_scaled[FRAC_BITS+7:FRAC_BITS];
        dark_scaled = {in_data.dark, 8'b0} - {8'b0, in_data.dark};
        dark_lvl    = dark_scaled[2*FRAC_BITS+7:2*FRAC_BITS];
        // 255 / 3840 = 17 / 256, so level = 17 * mix >> (2*FRAC_BITS + 8)
        mix_scaled  = {1'b0, in_data.mix, 4'b0} + {5'b0, in_data.mix};
        mix_lvl     = mix_scaled[2*FRAC_BITS+15:2*FRAC_BITS+8];

        case (in_data.sector)
            SEC_RED_YELLOW: begin
                rgb_next.red = full_lvl; rgb_next.green = mix_lvl;  rgb_next.blue = dark_lvl;
            end
            SEC_YELLOW_GREEN: begin
                rgb_next.red = mix_lvl;  rgb_next.green = full_lvl; rgb_next.blue = dark_lvl;
            end
            SEC_GREEN_CYAN: begin
                rgb_next.red = dark_lvl; rgb_next.green = full_lvl; rgb_next.blue = mix_lvl;
            end
            SEC_CYAN_BLUE: begin
                rgb_next.red = dark_lvl; rgb_next.green = mix_lvl;  rgb_next.blue = full_lvl;
            end
            SEC_BLUE_MAGENTA: begin
                rgb_next.red = mix_lvl;  rgb_next.green = dark_lvl; rgb_next.blue = full_lvl;
            end
            default: begin
                rgb_next.red = full_lvl; rgb_next.green = dark_lvl; rgb_next.blue = mix_lvl;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rgb_reg <= rgb_next;
        end
    end

endmodule

@@ design/hsv_to_rgb_converter_core.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: hue, saturation, brightness
// m_        out  m_tvalid/m_tready  m_tdata: red, green, blue
//
// One pixel per cycle sustained while m_tready stays high; each stage below is registered.
// Stages: clamp and sector, v*s multiply, chroma*weight multiply, mix add, level and select.
// Each stage holds its valid bit; a stage advances when it is empty or the next one advances.
// aresetn (synchronous, active low) empties the pipeline; no state passes between pixels.

module hsv_to_rgb_converter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [14:0] hue, [27:15] saturation, [40:28] brightness, [47:41] zero
    input  logic [hsv2rgb_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hsv2rgb_pkg::M_DATA_W-1:0]    m_tdata
);
    import hsv2rgb_pkg::*;

    logic  prep_valid;
    logic  prep_ready;
    prep_t prep_data;
    logic  mix_valid;
    logic  mix_ready;
    mix_t  mix_data;
    rgb_t  rgb_data;

    hsv2rgb_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[HUE_W-1:0]),
        .saturation (s_tdata[HUE_W+FRAC_W-1:HUE_W]),
        .brightness (s_tdata[HUE_W+2*FRAC_W-1:HUE_W+FRAC_W]),
        .out_valid  (prep_valid),
        .out_ready  (prep_ready),
        .out_data   (prep_data)
    );

    hsv2rgb_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    hsv2rgb_level u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb_data)
    );

    assign m_tdata = rgb_data;

endmodule

@@ design/hsv2rgb_checker.sv @@
`timescale 1ns / 1ps

module hsv2rgb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [hsv2rgb_pkg::S_DATA_W-1:0]    s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [hsv2rgb_pkg::M_DATA_W-1:0]    m_tdata
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a free sink frees every stage back to the input
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with sink ready");

    // an accepted beat reaches the output when the sink stays ready throughout
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready |=> m_tvalid)
        else $error("beat missing at output");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (.*);
